// ===== hw/rtl/thermostat_hysteresis_controller_defines.svh =====
// ---------------------------------------------------------------------------
// Thermostat controller assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef THERMOSTAT_HYSTERESIS_CONTROLLER_DEFINES_SVH
`define THERMOSTAT_HYSTERESIS_CONTROLLER_DEFINES_SVH

// Same-cycle implication.
`define THC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define THC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/thc_pkg.sv =====
// ---------------------------------------------------------------------------
// Thermostat controller package
// Item, result and configuration types plus fixed constants.
// ---------------------------------------------------------------------------
package thc_pkg;

    // Temperature fields: signed sixteenths of a degree
    localparam int TEMP_BITS   = 12;
    localparam int CFG_BITS    = 8;
    localparam int UPTIME_BITS = 32;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 5;
    localparam int REG_IDX_W   = 3;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_HYSTERESIS    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SETPOINT_STEP = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LOCKOUT       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DISPLAY_OFF   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SAVE_DELAY    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SENSOR_INT    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SETPOINT_MIN  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SETPOINT_MAX  = 3'd7;

    // Register reset values
    localparam logic [CFG_BITS-1:0] HYSTERESIS_RST    = 8'd8;
    localparam logic [CFG_BITS-1:0] SETPOINT_STEP_RST = 8'd8;
    localparam logic [CFG_BITS-1:0] LOCKOUT_RST       = 8'd60;
    localparam logic [CFG_BITS-1:0] DISPLAY_OFF_RST   = 8'd30;
    localparam logic [CFG_BITS-1:0] SAVE_DELAY_RST    = 8'd5;
    localparam logic [CFG_BITS-1:0] SENSOR_INT_RST    = 8'd5;
    localparam logic signed [TEMP_BITS-1:0] SETPOINT_MIN_RST = -12'sd480;
    localparam logic signed [TEMP_BITS-1:0] SETPOINT_MAX_RST = 12'sd960;

    // 22 degrees
    localparam logic signed [TEMP_BITS-1:0] SETPOINT_RST = 12'sd352;

    typedef enum logic [1:0] {
        TREND_SAME    = 2'd0,
        TREND_RISING  = 2'd1,
        TREND_FALLING = 2'd2
    } thc_trend_t;

    typedef struct packed {
        logic                        second_tick;
        logic                        sample_valid;
        logic signed [TEMP_BITS-1:0] sample;
        logic                        button_up;
        logic                        button_down;
        logic                        button_display;
    } thc_item_t;

    typedef struct packed {
        logic                        heat_relay;
        logic                        cool_relay;
        logic                        display_active;
        logic                        start_conversion;
        logic                        read_request;
        logic                        save_request;
        logic signed [TEMP_BITS-1:0] setpoint_now;
        thc_trend_t                  trend;
        logic [UPTIME_BITS-1:0]      uptime_seconds;
    } thc_result_t;

    typedef struct packed {
        logic [CFG_BITS-1:0]         hysteresis;
        logic [CFG_BITS-1:0]         setpoint_step;
        logic [CFG_BITS-1:0]         lockout_seconds;
        logic [CFG_BITS-1:0]         display_off_seconds;
        logic [CFG_BITS-1:0]         save_delay_seconds;
        logic [CFG_BITS-1:0]         sensor_interval_seconds;
        logic signed [TEMP_BITS-1:0] setpoint_min;
        logic signed [TEMP_BITS-1:0] setpoint_max;
    } thc_cfg_t;

endpackage

// ===== hw/rtl/thc_regs.sv =====
// ---------------------------------------------------------------------------
// Thermostat controller register file
// APB-style configuration registers; pready is tied high.
// ---------------------------------------------------------------------------
module thc_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [thc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [thc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [thc_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready,
    output thc_pkg::thc_cfg_t             cfg
);
    import thc_pkg::*;

    thc_cfg_t              cfg_reg;
    logic                  wr_en;
    logic [REG_IDX_W-1:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hysteresis              <= HYSTERESIS_RST;
            cfg_reg.setpoint_step           <= SETPOINT_STEP_RST;
            cfg_reg.lockout_seconds         <= LOCKOUT_RST;
            cfg_reg.display_off_seconds     <= DISPLAY_OFF_RST;
            cfg_reg.save_delay_seconds      <= SAVE_DELAY_RST;
            cfg_reg.sensor_interval_seconds <= SENSOR_INT_RST;
            cfg_reg.setpoint_min            <= SETPOINT_MIN_RST;
            cfg_reg.setpoint_max            <= SETPOINT_MAX_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_HYSTERESIS:    cfg_reg.hysteresis <= pwdata[CFG_BITS-1:0];
                REG_SETPOINT_STEP: cfg_reg.setpoint_step <= pwdata[CFG_BITS-1:0];
                REG_LOCKOUT:       cfg_reg.lockout_seconds <= pwdata[CFG_BITS-1:0];
                REG_DISPLAY_OFF:   cfg_reg.display_off_seconds <= pwdata[CFG_BITS-1:0];
                REG_SAVE_DELAY:    cfg_reg.save_delay_seconds <= pwdata[CFG_BITS-1:0];
                REG_SENSOR_INT:    cfg_reg.sensor_interval_seconds <= pwdata[CFG_BITS-1:0];
                REG_SETPOINT_MIN:  cfg_reg.setpoint_min <= $signed(pwdata[TEMP_BITS-1:0]);
                REG_SETPOINT_MAX:  cfg_reg.setpoint_max <= $signed(pwdata[TEMP_BITS-1:0]);
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_HYSTERESIS:    prdata = APB_DATA_W'(cfg_reg.hysteresis);
            REG_SETPOINT_STEP: prdata = APB_DATA_W'(cfg_reg.setpoint_step);
            REG_LOCKOUT:       prdata = APB_DATA_W'(cfg_reg.lockout_seconds);
            REG_DISPLAY_OFF:   prdata = APB_DATA_W'(cfg_reg.display_off_seconds);
            REG_SAVE_DELAY:    prdata = APB_DATA_W'(cfg_reg.save_delay_seconds);
            REG_SENSOR_INT:    prdata = APB_DATA_W'(cfg_reg.sensor_interval_seconds);
            REG_SETPOINT_MIN:  prdata = APB_DATA_W'(cfg_reg.setpoint_min);
            REG_SETPOINT_MAX:  prdata = APB_DATA_W'(cfg_reg.setpoint_max);
            default:           prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/thc_core.sv =====
// ---------------------------------------------------------------------------
// Thermostat controller pass logic
// Controller state and the combinational control pass for one item.
// ---------------------------------------------------------------------------
`include "thermostat_hysteresis_controller_defines.svh"

module thc_core #(
    parameter int TIMER_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  thc_pkg::thc_cfg_t    cfg,
    input  logic                 step,
    input  thc_pkg::thc_item_t   item,
    output thc_pkg::thc_result_t result
);
    import thc_pkg::*;

    // Interval compare at full precision, room for interval + 1
    localparam int CMP_W = ((TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS) + 2;
    localparam int SW    = TEMP_BITS + 2;
    localparam logic signed [SW-1:0] T_MAX = SW'((2 ** (TEMP_BITS - 1)) - 1);
    localparam logic signed [SW-1:0] T_MIN = -T_MAX - SW'(1);

    logic                        heat_on_reg,      heat_on_next;
    logic                        cool_on_reg,      cool_on_next;
    logic                        display_on_reg,   display_on_next;
    logic                        have_sample_reg,  have_sample_next;
    logic signed [TEMP_BITS-1:0] setpoint_reg,     setpoint_next;
    logic signed [TEMP_BITS-1:0] temperature_reg,  temperature_next;
    thc_trend_t                  trend_reg,        trend_next;
    logic [TIMER_BITS-1:0]       lockout_reg,      lockout_next;
    logic [TIMER_BITS-1:0]       save_timer_reg,   save_timer_next;
    logic [TIMER_BITS-1:0]       display_timer_reg, display_timer_next;
    logic [TIMER_BITS-1:0]       sensor_cnt_reg,   sensor_cnt_next;
    logic [UPTIME_BITS-1:0]      uptime_reg,       uptime_next;

    logic [TIMER_BITS-1:0]       cnt_inc;
    logic [CMP_W-1:0]            cnt_ext;
    logic [CMP_W-1:0]            int_ext;
    logic [TIMER_BITS-1:0]       lockout_load;
    logic [TIMER_BITS-1:0]       save_load;
    logic [TIMER_BITS-1:0]       display_load;
    logic signed [SW-1:0]        step_s;
    logic signed [SW-1:0]        hyst_s;
    logic signed [SW-1:0]        sp_s;
    logic signed [SW-1:0]        sp_up;
    logic signed [SW-1:0]        sp_dn;
    logic signed [SW-1:0]        sp_up_sat;
    logic signed [SW-1:0]        sp_dn_sat;
    logic signed [SW-1:0]        sp_new;
    logic signed [SW-1:0]        temp_new;
    logic                        start_pulse;
    logic                        read_pulse;
    logic                        save_pulse;

    assign cnt_inc      = sensor_cnt_reg + TIMER_BITS'(1);
    assign cnt_ext      = CMP_W'(cnt_inc);
    assign int_ext      = CMP_W'(cfg.sensor_interval_seconds);
    assign lockout_load = TIMER_BITS'(cfg.lockout_seconds);
    assign save_load    = TIMER_BITS'(cfg.save_delay_seconds);
    assign display_load = TIMER_BITS'(cfg.display_off_seconds);

    // Setpoint step: clamp at own limit only, then saturate to the field range
    assign step_s = SW'({1'b0, cfg.setpoint_step});
    assign hyst_s = SW'({1'b0, cfg.hysteresis});
    assign sp_s   = SW'(setpoint_reg);
    assign sp_up  = (sp_s + step_s > SW'(cfg.setpoint_max)) ? SW'(cfg.setpoint_max)
                                                            : sp_s + step_s;
    assign sp_dn  = (sp_s - step_s < SW'(cfg.setpoint_min)) ? SW'(cfg.setpoint_min)
                                                            : sp_s - step_s;
    assign sp_up_sat = (sp_up > T_MAX) ? T_MAX : ((sp_up < T_MIN) ? T_MIN : sp_up);
    assign sp_dn_sat = (sp_dn > T_MAX) ? T_MAX : ((sp_dn < T_MIN) ? T_MIN : sp_dn);

    always_comb
    begin
        sensor_cnt_next    = sensor_cnt_reg;
        save_timer_next    = save_timer_reg;
        display_timer_next = display_timer_reg;
        display_on_next    = display_on_reg;
        lockout_next       = lockout_reg;
        uptime_next        = uptime_reg;
        start_pulse        = 1'b0;
        read_pulse         = 1'b0;
        save_pulse         = 1'b0;
        trend_next         = trend_reg;
        temperature_next   = temperature_reg;
        have_sample_next   = have_sample_reg;
        setpoint_next      = setpoint_reg;
        heat_on_next       = heat_on_reg;
        cool_on_next       = cool_on_reg;

        // One-second timers
        if (item.second_tick)
        begin
            sensor_cnt_next = cnt_inc;
            if (cnt_ext == int_ext)
            begin
                start_pulse = 1'b1;
            end
            else if (cnt_ext > int_ext + CMP_W'(1))
            begin
                read_pulse      = 1'b1;
                sensor_cnt_next = '0;
            end
            if (save_timer_reg != '0)
            begin
                save_timer_next = save_timer_reg - TIMER_BITS'(1);
                save_pulse      = (save_timer_reg == TIMER_BITS'(1));
            end
            if (display_timer_reg != '0)
            begin
                display_timer_next = display_timer_reg - TIMER_BITS'(1);
                if (display_timer_reg == TIMER_BITS'(1))
                begin
                    display_on_next = 1'b0;
                end
            end
            if (lockout_reg != '0)
            begin
                lockout_next = lockout_reg - TIMER_BITS'(1);
            end
            uptime_next = uptime_reg + UPTIME_BITS'(1);
        end

        // Sample and trend
        if (item.sample_valid)
        begin
            if (!have_sample_reg || item.sample == temperature_reg)
            begin
                trend_next = TREND_SAME;
            end
            else if (item.sample > temperature_reg)
            begin
                trend_next = TREND_RISING;
            end
            else
            begin
                trend_next = TREND_FALLING;
            end
            temperature_next = item.sample;
            have_sample_next = 1'b1;
        end

        // Buttons: up over down over display
        if (item.button_up)
        begin
            setpoint_next      = sp_up_sat[TEMP_BITS-1:0];
            save_timer_next    = save_load;
            display_timer_next = display_load;
            display_on_next    = 1'b1;
        end
        else if (item.button_down)
        begin
            setpoint_next      = sp_dn_sat[TEMP_BITS-1:0];
            save_timer_next    = save_load;
            display_timer_next = display_load;
            display_on_next    = 1'b1;
        end
        else if (item.button_display)
        begin
            display_timer_next = display_load;
            display_on_next    = 1'b1;
        end

        // Relays; heat first so its lockout blocks cool in the same pass
        sp_new   = SW'(setpoint_next);
        temp_new = SW'(temperature_next);
        if (!have_sample_next)
        begin
            heat_on_next = 1'b0;
            cool_on_next = 1'b0;
        end
        else
        begin
            if (!heat_on_reg)
            begin
                heat_on_next = (temp_new < sp_new - hyst_s) && (lockout_next == '0);
            end
            else if (temp_new >= sp_new)
            begin
                heat_on_next = 1'b0;
                lockout_next = lockout_load;
            end
            if (!cool_on_reg)
            begin
                cool_on_next = (temp_new > sp_new + hyst_s) && (lockout_next == '0);
            end
            else if (temp_new <= sp_new)
            begin
                cool_on_next = 1'b0;
                lockout_next = lockout_load;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heat_on_reg       <= 1'b0;
            cool_on_reg       <= 1'b0;
            display_on_reg    <= 1'b1;
            have_sample_reg   <= 1'b0;
            setpoint_reg      <= SETPOINT_RST;
            temperature_reg   <= '0;
            trend_reg         <= TREND_SAME;
            lockout_reg       <= '0;
            save_timer_reg    <= '0;
            display_timer_reg <= TIMER_BITS'(DISPLAY_OFF_RST);
            sensor_cnt_reg    <= '0;
            uptime_reg        <= '0;
        end
        else if (step)
        begin
            heat_on_reg       <= heat_on_next;
            cool_on_reg       <= cool_on_next;
            display_on_reg    <= display_on_next;
            have_sample_reg   <= have_sample_next;
            setpoint_reg      <= setpoint_next;
            temperature_reg   <= temperature_next;
            trend_reg         <= trend_next;
            lockout_reg       <= lockout_next;
            save_timer_reg    <= save_timer_next;
            display_timer_reg <= display_timer_next;
            sensor_cnt_reg    <= sensor_cnt_next;
            uptime_reg        <= uptime_next;
        end
    end

    always_comb
    begin
        result.heat_relay       = heat_on_next;
        result.cool_relay       = cool_on_next;
        result.display_active   = display_on_next;
        result.start_conversion = start_pulse;
        result.read_request     = read_pulse;
        result.save_request     = save_pulse;
        result.setpoint_now     = setpoint_next;
        result.trend            = trend_next;
        result.uptime_seconds   = uptime_next;
    end

    `THC_ASSERT_IMPLIES(a_relays_exclusive, 1'b1, !(heat_on_reg && cool_on_reg), "heat and cool both on")
    `THC_ASSERT_IMPLIES(a_no_relay_before_sample, !have_sample_reg, !heat_on_reg && !cool_on_reg, "relay on before first sample")
    `THC_ASSERT_IMPLIES(a_heat_off_locks, $fell(heat_on_reg), lockout_reg == TIMER_BITS'($past(cfg.lockout_seconds)), "heat off without lockout load")
    `THC_ASSERT_IMPLIES(a_display_off_idle, !display_on_reg, display_timer_reg == '0, "display off with timer running")

endmodule

// ===== hw/rtl/thc_out_buf.sv =====
// ---------------------------------------------------------------------------
// Thermostat controller result register
// Holds one result item until the receiver takes it.
// ---------------------------------------------------------------------------
module thc_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load_valid,
    output logic                 load_ready,
    input  thc_pkg::thc_result_t load_data,
    output logic                 result_valid,
    input  logic                 result_ready,
    output thc_pkg::thc_result_t result
);
    import thc_pkg::*;

    logic        valid_reg;
    thc_result_t data_reg;

    assign load_ready   = !valid_reg || result_ready;
    assign result_valid = valid_reg;
    assign result       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load_ready)
        begin
            valid_reg <= load_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ready && load_valid)
        begin
            data_reg <= load_data;
        end
    end

endmodule

// ===== hw/rtl/thermostat_hysteresis_controller.sv =====
// ---------------------------------------------------------------------------
// Thermostat hysteresis controller
// Bang-bang heat/cool control with timers, setpoint buttons and sensor schedule.
// ---------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item): one control pass per item,
//   carrying the second tick, an optional sensor sample and button levels.
//   result channel (result_valid/result_ready/result): exactly one result
//   item per input item, in order.
//   APB port: eight configuration registers at byte offsets 0x00..0x1C;
//   write only while no item is in flight. pready is tied high.
// Timing:
//   An item lands in the input register at the accepting edge; its pass is
//   evaluated from that register and captured in the result register once
//   the result register can load, which raises result_valid. One item per
//   cycle sustained while the receiver keeps result_ready high; the pass is
//   a single combinational step on the controller state.
// Reset: relays off, display on, setpoint 22 degrees, timers cleared but the
//   display timer (at its default), registers at defaults, both channels empty.
// Stall: a held result keeps its register; one more item waits in the input
//   register, then item_ready drops until the receiver takes the result.
// ---------------------------------------------------------------------------
module thermostat_hysteresis_controller #(
    parameter int TIMER_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  thc_pkg::thc_item_t             item,
    output logic                           result_valid,
    input  logic                           result_ready,
    output thc_pkg::thc_result_t           result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [thc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [thc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [thc_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import thc_pkg::*;

    thc_cfg_t    cfg;
    logic        stage_valid_reg;
    thc_item_t   stage_item_reg;
    logic        pass_ready;
    logic        pass_fire;
    thc_result_t pass_result;

    assign item_ready = !stage_valid_reg || pass_ready;
    assign pass_fire  = stage_valid_reg && pass_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            stage_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            stage_item_reg <= item;
        end
    end

    thc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    thc_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (pass_fire),
        .item   (stage_item_reg),
        .result (pass_result)
    );

    thc_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_valid   (stage_valid_reg),
        .load_ready   (pass_ready),
        .load_data    (pass_result),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
